// ===== hw/rtl/spin_image_accumulator_top_macros.svh =====
// ----------------------------------------------------------------------------
// Spin image accumulator assertion macros
// Shorthands for the concurrent checks of the accumulator top level.
// ----------------------------------------------------------------------------
`ifndef SPIN_IMAGE_ACCUMULATOR_TOP_MACROS_SVH
`define SPIN_IMAGE_ACCUMULATOR_TOP_MACROS_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define SIA_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define SIA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/sia_pkg.sv =====
// ----------------------------------------------------------------------------
// Spin image accumulator package
// Beat types, command and register codes, and reset values.
// ----------------------------------------------------------------------------
package sia_pkg;

  localparam int unsigned RHO_BINS_DEF         = 64;
  localparam int unsigned Z_BINS_DEF           = 64;
  localparam int unsigned WEIGHT_FRAC_BITS_DEF = 8;

  // Fraction bits of a scaled bin position.
  localparam int unsigned POS_FRAC = 20;

  typedef enum logic [1:0] {
    CMD_ACCUM = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_BASE_X    = 3'd0,
    REG_BASE_Y    = 3'd1,
    REG_BASE_Z    = 3'd2,
    REG_NORMAL_X  = 3'd3,
    REG_NORMAL_Y  = 3'd4,
    REG_NORMAL_Z  = 3'd5,
    REG_BIN_SCALE = 3'd6,
    REG_Z_LOW_BIN = 3'd7
  } reg_e;

  localparam logic signed [15:0] NORMAL_Z_RST  = 16'sd16384;
  localparam logic [15:0]        BIN_SCALE_RST = 16'd256;
  localparam logic signed [6:0]  Z_LOW_RST     = -7'sd32;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [5:0]         read_rho_bin;
    logic [5:0]         read_z_bin;
  } in_item_t;

  typedef struct packed {
    logic [31:0] bin_value;
    logic        in_range;
    logic        saturated;
  } result_t;

endpackage

// ===== hw/rtl/spin_image_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// Spin image accumulator
// Bins 3D points into a bilinear spin image held in one block RAM.
// ----------------------------------------------------------------------------
// Usage: a command beat is taken when start is high and busy is low, and each
// command returns exactly one result beat on result_o, marked by done_o for a
// single cycle. The receiver cannot stall that beat, so it must sample it in
// that cycle. An accumulate command runs the cross and dot products on the
// shared 33x16 multiplier, then the squares, then the bit-serial square root,
// then the scaling and the image check, and then a read and a write back for
// each of up to four bins through the RAM's one read and one write port. A
// point outside the image returns right after the check. A read returns its
// bin by way of the ST_RDATA state, and a no-op answers the cycle after its
// beat. A clear walks all RHO_BINS*Z_BINS bins, one a cycle, and then returns.
// After reset the same clearing pass runs with busy high before the first
// command is taken; configuration writes are taken at any time, but should
// only be made while the block is idle.
// ----------------------------------------------------------------------------
`include "spin_image_accumulator_top_macros.svh"

module spin_image_accumulator_top #(
  parameter int unsigned RHO_BINS         = sia_pkg::RHO_BINS_DEF,
  parameter int unsigned Z_BINS           = sia_pkg::Z_BINS_DEF,
  parameter int unsigned WEIGHT_FRAC_BITS = sia_pkg::WEIGHT_FRAC_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  sia_pkg::in_item_t in_item_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i,
  output logic              done_o,
  output sia_pkg::result_t  result_o
);

  localparam int unsigned DEPTH = RHO_BINS * Z_BINS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned RW    = $clog2(RHO_BINS + 1);
  localparam int unsigned ZW    = $clog2(Z_BINS + 1);
  localparam int unsigned W     = WEIGHT_FRAC_BITS;
  localparam int unsigned PF    = sia_pkg::POS_FRAC;
  localparam int unsigned PW    = 2 * W + 2;
  localparam int unsigned SH    = 2 * W - 8;
  localparam logic [PW:0] RND   = (PW + 1)'((2 ** SH) >> 1);
  localparam logic [W:0]  ONE   = (W + 1)'(2 ** W);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_SQ, ST_SQRT, ST_SCALE, ST_CHECK,
    ST_RD, ST_WR, ST_RDATA
  } state_e;

  state_e state_q;

  // Configuration registers.
  logic signed [31:0] base_x_q, base_y_q, base_z_q;
  logic signed [15:0] normal_x_q, normal_y_q, normal_z_q;
  logic [15:0]        scale_q;
  logic signed [6:0]  zlow_q;

  // Datapath registers.
  logic signed [32:0] dx_q, dy_q, dz_q;
  logic signed [48:0] prod_q, hold_q;
  logic signed [50:0] dot_q;
  logic [31:0]        cx_q, cy_q, cz_q;
  logic [63:0]        sq_q, sum_q, rem_q, res_q, bit_q;
  logic [47:0]        rpos_q;
  logic signed [49:0] zpos_q;
  logic [RW-1:0]      ri_q;
  logic [ZW-1:0]      zrow_q;
  logic [W-1:0]       fr_q, fz_q;
  logic [8:0]         w_q;
  logic [AW-1:0]      addr_q, clr_q;
  logic [3:0]         mk_q;
  logic [1:0]         sqk_q, nb_q;
  logic [4:0]         it_q;
  logic               sat_q, reply_q, done_q;
  sia_pkg::result_t   res_out_q;

  // Memory port.
  logic [31:0]   mem [DEPTH];
  logic [31:0]   rdata_q;
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [31:0]   mem_wdata;

  logic accept;
  assign accept      = start && !busy;
  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign done_o      = done_q;
  assign result_o    = res_out_q;

  // Shared product multiplier, one product per cycle.
  logic signed [32:0] dsel;
  logic signed [15:0] nsel;
  logic signed [48:0] prod;
  always_comb begin
    case (mk_q)
      4'd0:    begin dsel = dy_q; nsel = normal_z_q; end
      4'd1:    begin dsel = dz_q; nsel = normal_y_q; end
      4'd2:    begin dsel = dz_q; nsel = normal_x_q; end
      4'd3:    begin dsel = dx_q; nsel = normal_z_q; end
      4'd4:    begin dsel = dx_q; nsel = normal_y_q; end
      4'd5:    begin dsel = dy_q; nsel = normal_x_q; end
      4'd6:    begin dsel = dx_q; nsel = normal_x_q; end
      4'd7:    begin dsel = dy_q; nsel = normal_y_q; end
      default: begin dsel = dz_q; nsel = normal_z_q; end
    endcase
    prod = 49'(dsel) * 49'(nsel);
  end

  // A cross component is |hold - prod| truncated to Q.12.
  logic signed [49:0] cdiff;
  logic [49:0]        cmag;
  logic [31:0]        cval;
  assign cdiff = 50'(hold_q) - 50'(prod_q);
  assign cmag  = cdiff[49] ? 50'(-cdiff) : 50'(cdiff);
  assign cval  = cmag[49:18];

  logic [31:0] csel;
  logic [63:0] sq;
  always_comb begin
    case (sqk_q)
      2'd0:    csel = cx_q;
      2'd1:    csel = cy_q;
      default: csel = cz_q;
    endcase
    sq = 64'(csel) * 64'(csel);
  end

  // Square root step.
  logic [63:0] cand;
  logic        ge;
  assign cand = res_q + bit_q;
  assign ge   = (rem_q >= cand);

  // Scaling and image bounds.
  logic signed [32:0] z12;
  logic signed [11:0] zlo12, zhi12;
  logic signed [49:0] zlo_pos, zhi_pos;
  logic signed [29:0] zi;
  logic signed [29:0] zrow_full;
  logic               in_img;
  assign z12       = 33'(dot_q >>> 18);
  assign zlo12     = 12'(zlow_q);
  assign zhi12     = zlo12 + 12'(Z_BINS);
  assign zlo_pos   = 50'(zlo12) <<< PF;
  assign zhi_pos   = 50'(zhi12) <<< PF;
  assign zi        = 30'(zpos_q >>> PF);
  assign zrow_full = zi - 30'(zlo12);
  assign in_img    = (rpos_q < (48'(RHO_BINS) << PF)) &&
                     (zpos_q >= zlo_pos) && (zpos_q < zhi_pos);

  // Neighbor address and weight.
  logic [RW-1:0] nr;
  logic [ZW-1:0] nz;
  logic          nb_ok;
  logic [AW-1:0] nb_addr;
  logic [W:0]    fa, fb;
  logic [PW-1:0] wprod;
  logic [PW:0]   wrnd;
  logic [8:0]    wval;
  assign nr      = ri_q + RW'(nb_q[0]);
  assign nz      = zrow_q + ZW'(nb_q[1]);
  assign nb_ok   = (32'(nr) < RHO_BINS) && (32'(nz) < Z_BINS);
  assign nb_addr = AW'(32'(nz) * RHO_BINS + 32'(nr));
  assign fa      = nb_q[0] ? (W + 1)'(fr_q) : ONE - (W + 1)'(fr_q);
  assign fb      = nb_q[1] ? (W + 1)'(fz_q) : ONE - (W + 1)'(fz_q);
  assign wprod   = PW'(fa) * PW'(fb);
  assign wrnd    = (PW + 1)'(wprod) + RND;
  assign wval    = 9'(wrnd >> SH);

  // Saturating bin update.
  logic [32:0] bsum;
  logic        ovf;
  assign bsum = 33'(rdata_q) + 33'(w_q);
  assign ovf  = bsum[32];

  // Read command.
  logic          rd_ok;
  logic [AW-1:0] rd_addr;
  assign rd_ok   = (32'(in_item_i.read_rho_bin) < RHO_BINS) &&
                   (32'(in_item_i.read_z_bin) < Z_BINS);
  assign rd_addr = AW'(32'(in_item_i.read_z_bin) * RHO_BINS +
                       32'(in_item_i.read_rho_bin));

  always_comb begin
    mem_raddr = (state_q == ST_RD) ? nb_addr : rd_addr;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = ovf ? 32'hFFFF_FFFF : bsum[31:0];
    case (state_q)
      ST_WR: mem_we = 1'b1;
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      base_x_q   <= '0;
      base_y_q   <= '0;
      base_z_q   <= '0;
      normal_x_q <= '0;
      normal_y_q <= '0;
      normal_z_q <= sia_pkg::NORMAL_Z_RST;
      scale_q    <= sia_pkg::BIN_SCALE_RST;
      zlow_q     <= sia_pkg::Z_LOW_RST;
      dx_q <= '0; dy_q <= '0; dz_q <= '0;
      prod_q <= '0; hold_q <= '0; dot_q <= '0;
      cx_q <= '0; cy_q <= '0; cz_q <= '0;
      sq_q <= '0; sum_q <= '0; rem_q <= '0; res_q <= '0; bit_q <= '0;
      rpos_q <= '0; zpos_q <= '0; ri_q <= '0; zrow_q <= '0;
      fr_q <= '0; fz_q <= '0; w_q <= '0; addr_q <= '0; clr_q <= '0;
      mk_q <= '0; sqk_q <= '0; nb_q <= '0; it_q <= '0;
      sat_q      <= 1'b0;
      reply_q    <= 1'b0;
      done_q     <= 1'b0;
      res_out_q  <= '0;
    end else begin
      done_q <= 1'b0;

      if (cfg_valid_i && cfg_ready_o) begin
        case (sia_pkg::reg_e'(cfg_index_i))
          sia_pkg::REG_BASE_X:    base_x_q   <= cfg_data_i;
          sia_pkg::REG_BASE_Y:    base_y_q   <= cfg_data_i;
          sia_pkg::REG_BASE_Z:    base_z_q   <= cfg_data_i;
          sia_pkg::REG_NORMAL_X:  normal_x_q <= cfg_data_i[15:0];
          sia_pkg::REG_NORMAL_Y:  normal_y_q <= cfg_data_i[15:0];
          sia_pkg::REG_NORMAL_Z:  normal_z_q <= cfg_data_i[15:0];
          sia_pkg::REG_BIN_SCALE: scale_q    <= cfg_data_i[15:0];
          sia_pkg::REG_Z_LOW_BIN: zlow_q     <= cfg_data_i[6:0];
          default:                zlow_q     <= zlow_q;
        endcase
      end

      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(DEPTH - 1)) begin
            state_q <= ST_IDLE;
            if (reply_q) begin
              done_q    <= 1'b1;
              res_out_q <= '0;
            end
          end
        end

        ST_IDLE: begin
          if (accept) begin
            case (sia_pkg::cmd_e'(in_item_i.command))
              sia_pkg::CMD_ACCUM: begin
                dx_q    <= 33'(in_item_i.point_x) - 33'(base_x_q);
                dy_q    <= 33'(in_item_i.point_y) - 33'(base_y_q);
                dz_q    <= 33'(in_item_i.point_z) - 33'(base_z_q);
                mk_q    <= '0;
                state_q <= ST_MUL;
              end
              sia_pkg::CMD_READ: begin
                if (rd_ok) begin
                  state_q <= ST_RDATA;
                end else begin
                  done_q    <= 1'b1;
                  res_out_q <= '0;
                end
              end
              sia_pkg::CMD_CLEAR: begin
                clr_q   <= '0;
                reply_q <= 1'b1;
                state_q <= ST_CLEAR;
              end
              default: begin
                done_q    <= 1'b1;
                res_out_q <= '0;
              end
            endcase
          end
        end

        // Products are registered in prod_q after their operands are selected by mk_q.
        ST_MUL: begin
          prod_q <= prod;
          mk_q   <= mk_q + 4'd1;
          case (mk_q)
            4'd1, 4'd3, 4'd5: hold_q <= prod_q;
            4'd2: cx_q  <= cval;
            4'd4: cy_q  <= cval;
            4'd6: cz_q  <= cval;
            4'd7: dot_q <= 51'(prod_q);
            4'd8: dot_q <= dot_q + 51'(prod_q);
            4'd9: begin
              dot_q   <= dot_q + 51'(prod_q);
              sqk_q   <= '0;
              state_q <= ST_SQ;
            end
            default: hold_q <= hold_q;
          endcase
        end

        ST_SQ: begin
          sq_q  <= sq;
          sqk_q <= sqk_q + 2'd1;
          case (sqk_q)
            2'd1: sum_q <= sq_q;
            2'd2: sum_q <= sum_q + sq_q;
            2'd3: begin
              rem_q   <= sum_q + sq_q;
              res_q   <= '0;
              bit_q   <= 64'h4000_0000_0000_0000;
              it_q    <= '0;
              state_q <= ST_SQRT;
            end
            default: sum_q <= sum_q;
          endcase
        end

        ST_SQRT: begin
          if (ge) begin
            rem_q <= rem_q - cand;
            res_q <= (res_q >> 1) + bit_q;
          end else begin
            res_q <= res_q >> 1;
          end
          bit_q <= bit_q >> 2;
          it_q  <= it_q + 5'd1;
          if (it_q == 5'd31) begin
            state_q <= ST_SCALE;
          end
        end

        ST_SCALE: begin
          rpos_q  <= 48'(res_q[31:0]) * 48'(scale_q);
          zpos_q  <= 50'(z12) * 50'(signed'({1'b0, scale_q}));
          state_q <= ST_CHECK;
        end

        ST_CHECK: begin
          if (!in_img) begin
            done_q    <= 1'b1;
            res_out_q <= '0;
            state_q   <= ST_IDLE;
          end else begin
            ri_q    <= rpos_q[PF +: RW];
            zrow_q  <= ZW'(zrow_full);
            fr_q    <= rpos_q[PF - W +: W];
            fz_q    <= zpos_q[PF - W +: W];
            nb_q    <= '0;
            sat_q   <= 1'b0;
            state_q <= ST_RD;
          end
        end

        // Neighbors beyond the image edge are skipped.
        ST_RD: begin
          if (nb_ok) begin
            addr_q  <= nb_addr;
            w_q     <= wval;
            state_q <= ST_WR;
          end else if (nb_q == 2'd3) begin
            done_q    <= 1'b1;
            res_out_q <= '{bin_value: '0, in_range: 1'b1, saturated: sat_q};
            state_q   <= ST_IDLE;
          end else begin
            nb_q <= nb_q + 2'd1;
          end
        end

        ST_WR: begin
          sat_q <= sat_q | ovf;
          if (nb_q == 2'd3) begin
            done_q    <= 1'b1;
            res_out_q <= '{bin_value: '0, in_range: 1'b1, saturated: sat_q | ovf};
            state_q   <= ST_IDLE;
          end else begin
            nb_q    <= nb_q + 2'd1;
            state_q <= ST_RD;
          end
        end

        ST_RDATA: begin
          done_q    <= 1'b1;
          res_out_q <= '{bin_value: rdata_q, in_range: 1'b0, saturated: 1'b0};
          state_q   <= ST_IDLE;
        end

        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // A result beat is only ever shown once the sequencer is back at rest.
  `SIA_ASSERT_IMP(a_done_idle, done_o, !busy, "result beat while busy")
  // Saturation can only be flagged for a point that landed in the image.
  `SIA_ASSERT_IMP(a_sat_in_range, done_o && result_o.saturated, result_o.in_range, "saturated without in_range")
  // A taken command either starts work or answers in the next cycle.
  `SIA_ASSERT_NXT(a_accept_moves, accept, busy || done_o, "accepted command lost")

endmodule
